// File: sv/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and constants for the PCM volume and pan scaler
// Transaction payloads, configuration view, sample format codes and the
// fixed widths of the scaling datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pvs_pkg;

  // Sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_S32 = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_VOLUME   = 2'd2;
  localparam logic [1:0] REG_PAN      = 2'd3;

  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 8;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int REM_W    = 11;

  localparam logic [1:0]  RST_FORMAT   = FMT_S16;
  localparam logic [3:0]  RST_CHANNELS = 4'd2;
  localparam logic [3:0]  STEREO       = 4'd2;
  localparam logic [7:0]  RST_VOLUME   = 8'd255;
  localparam logic [7:0]  PAN_UNITY    = 8'd128;
  localparam logic [7:0]  OFFSET8      = 8'h80;

  typedef struct packed {
    logic [31:0] sample_in;
    logic        is_right_channel;
    logic        block_end;
  } in_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        block_end_out;
  } out_t;

  typedef struct packed {
    logic [1:0]        sample_format;
    logic [3:0]        channel_count;
    logic [7:0]        volume;
    logic signed [7:0] pan;
  } cfg_t;

  // Side information that travels with each sample down the pipeline
  typedef struct packed {
    logic [1:0] fmt;
    logic       neg;
    logic       block_end;
  } tag_t;

endpackage

`default_nettype wire

// File: sv/pvs_cfg.sv
// ----------------------------------------------------------------------------
// pvs_cfg: configuration register file
// APB-style write/read access to format, channel count, volume and pan.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pvs_pkg::cfg_t cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= pvs_pkg::RST_FORMAT;
      cfg.channel_count <= pvs_pkg::RST_CHANNELS;
      cfg.volume        <= pvs_pkg::RST_VOLUME;
      cfg.pan           <= '0;
    end else if (wr_en) begin
      unique case (idx)
        pvs_pkg::REG_FORMAT:   cfg.sample_format <= pwdata[1:0];
        pvs_pkg::REG_CHANNELS: cfg.channel_count <= pwdata[3:0];
        pvs_pkg::REG_VOLUME:   cfg.volume        <= pwdata[7:0];
        pvs_pkg::REG_PAN:      cfg.pan           <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pvs_pkg::REG_FORMAT:   prdata = {30'd0, cfg.sample_format};
      pvs_pkg::REG_CHANNELS: prdata = {28'd0, cfg.channel_count};
      pvs_pkg::REG_VOLUME:   prdata = {24'd0, cfg.volume};
      pvs_pkg::REG_PAN:      prdata = {24'd0, cfg.pan};
    endcase
  end

endmodule

`default_nettype wire

// File: sv/pvs_front.sv
// ----------------------------------------------------------------------------
// pvs_front: decode and multiply stages
// Stage A turns raw bits into sign and magnitude and picks the channel gain;
// stage B forms magnitude * gain plus the rounding offset.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  pvs_pkg::cfg_t               cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  pvs_pkg::in_t                up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [pvs_pkg::PROD_W-1:0]  dn_prod,
  output pvs_pkg::tag_t               dn_tag
);

  logic [32:0] dec;
  logic [31:0] mag;
  logic [7:0]  pan_bits;
  logic [7:0]  pan_k;
  logic        use_pan;
  logic [15:0] pan_prod;
  logic [7:0]  gain;

  logic        a_valid;
  logic        a_load;
  logic [31:0] a_mag;
  logic [7:0]  a_gain;
  pvs_pkg::tag_t a_tag;
  logic        b_load;

  // Sign-extend to 33 bits; the 8-bit path removes the offset first
  always_comb begin
    unique case (cfg.sample_format)
      pvs_pkg::FMT_U8:  dec = {25'd0, up_data.sample_in[7:0]} - 33'd128;
      pvs_pkg::FMT_S16: dec = {{17{up_data.sample_in[15]}}, up_data.sample_in[15:0]};
      pvs_pkg::FMT_S24: dec = {{9{up_data.sample_in[23]}}, up_data.sample_in[23:0]};
      pvs_pkg::FMT_S32: dec = {up_data.sample_in[31], up_data.sample_in};
    endcase
    mag = dec[32] ? (~dec[31:0] + 32'd1) : dec[31:0];
  end

  // Attenuate the channel away from the pan: round(volume * k / 128)
  always_comb begin
    pan_bits = cfg.pan;
    pan_k    = '0;
    use_pan  = 1'b0;
    if (cfg.channel_count == pvs_pkg::STEREO) begin
      if (pan_bits[7] && up_data.is_right_channel) begin
        use_pan = 1'b1;
        pan_k   = pan_bits + pvs_pkg::PAN_UNITY;
      end else if (!pan_bits[7] && (pan_bits != 8'd0) && !up_data.is_right_channel) begin
        use_pan = 1'b1;
        pan_k   = pvs_pkg::PAN_UNITY - pan_bits;
      end
    end
    pan_prod = 16'(cfg.volume) * 16'(pan_k) + 16'd64;
    gain     = use_pan ? pan_prod[14:7] : cfg.volume;
  end

  assign b_load   = !dn_valid || dn_ready;
  assign a_load   = !a_valid || b_load;
  assign up_ready = a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && up_valid) begin
      a_mag     <= mag;
      a_gain    <= gain;
      a_tag.fmt <= cfg.sample_format;
      a_tag.neg <= dec[32];
      a_tag.block_end <= up_data.block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (b_load) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      dn_prod <= pvs_pkg::PROD_W'(a_mag) * pvs_pkg::PROD_W'(a_gain)
                 + pvs_pkg::PROD_W'(127);
      dn_tag  <= a_tag;
    end
  end

`ifndef ASSERT_OFF
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_gain <= cfg.volume))
    else $error("pan gain exceeds master volume");
`endif

endmodule

`default_nettype wire

// File: sv/pvs_div255.sv
// ----------------------------------------------------------------------------
// pvs_div255: divide-by-255 stages
// Stage C estimates y/255 as a sum of byte shifts; stage D corrects the
// estimate from the remainder, which stays below five times the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_div255 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [pvs_pkg::PROD_W-1:0]  up_prod,
  input  pvs_pkg::tag_t               up_tag,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [31:0]                 dn_quo,
  output pvs_pkg::tag_t               dn_tag
);

  logic [32:0] est_sum;
  logic        c_valid;
  logic        c_load;
  logic [pvs_pkg::PROD_W-1:0] c_prod;
  logic [31:0] c_est;
  pvs_pkg::tag_t c_tag;
  logic        d_load;
  logic [pvs_pkg::REM_W-1:0] rem;
  logic [2:0]  fix;

  // y/255 = y/256 + y/2^16 + ...; dropped fractions leave at most 4 short
  assign est_sum = 33'(up_prod[39:8]) + 33'(up_prod[39:16])
                 + 33'(up_prod[39:24]) + 33'(up_prod[39:32]);

  // Remainder y - 255*est, exact in 11 bits since it lies below 1275
  assign rem = c_prod[pvs_pkg::REM_W-1:0] - {c_est[2:0], 8'd0} + c_est[pvs_pkg::REM_W-1:0];
  assign fix = {2'd0, rem >= 11'd255} + {2'd0, rem >= 11'd510}
             + {2'd0, rem >= 11'd765} + {2'd0, rem >= 11'd1020};

  assign d_load   = !dn_valid || dn_ready;
  assign c_load   = !c_valid || d_load;
  assign up_ready = c_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load && up_valid) begin
      c_prod <= up_prod;
      c_est  <= est_sum[31:0];
      c_tag  <= up_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (d_load) begin
      dn_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load && c_valid) begin
      dn_quo <= c_est + 32'(fix);
      dn_tag <= c_tag;
    end
  end

`ifndef ASSERT_OFF
  rem_in_range: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (rem < 11'd1275))
    else $error("divide-by-255 estimate out of correction range");
`endif

endmodule

`default_nettype wire

// File: sv/pcm_volume_pan_scaler.sv
// ----------------------------------------------------------------------------
// pcm_volume_pan_scaler: PCM sample volume and stereo pan scaler
// Scales each PCM sample by gain/255, with pan attenuation in stereo.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one sample per transaction (src_valid/src_stall/src_data),
//   raw bits right-aligned; is_right_channel picks the pan side in stereo.
//   dst channel: the scaled sample in the same format, upper bits zero,
//   with block_end carried through (dst_valid/dst_stall/dst_data).
//   APB port: format, channel count, volume and pan at byte addresses
//   0, 4, 8 and 12; write them only while no sample is in flight.
// Pipeline: five register stages (decode, multiply, divide estimate,
//   divide correction, output encode).
// Throughput: one sample per cycle while dst_stall is low; the 32x8 multiply in the second stage
//   and the shift-sum estimate in the third set the clock.
// Reset: clears all valid bits and loads format 16-bit, two channels,
//   volume 255 and pan 0.
// Stall: dst_stall holds the output register; empty stages behind it keep
//   filling, and src_stall rises only once every stage holds a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_volume_pan_scaler (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  pvs_pkg::in_t  src_data,
  output logic          dst_valid,
  input  logic          dst_stall,
  output pvs_pkg::out_t dst_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  pvs_pkg::cfg_t cfg;

  logic          front_ready;
  logic          mul_valid;
  logic          mul_ready;
  logic [pvs_pkg::PROD_W-1:0] mul_prod;
  pvs_pkg::tag_t mul_tag;

  logic          quo_valid;
  logic          quo_ready;
  logic [31:0]   quo;
  pvs_pkg::tag_t quo_tag;

  logic [31:0]   sres;
  logic [31:0]   enc;

  pvs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pvs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (src_valid),
    .up_ready (front_ready),
    .up_data  (src_data),
    .dn_valid (mul_valid),
    .dn_ready (mul_ready),
    .dn_prod  (mul_prod),
    .dn_tag   (mul_tag)
  );

  pvs_div255 u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mul_valid),
    .up_ready (mul_ready),
    .up_prod  (mul_prod),
    .up_tag   (mul_tag),
    .dn_valid (quo_valid),
    .dn_ready (quo_ready),
    .dn_quo   (quo),
    .dn_tag   (quo_tag)
  );

  assign src_stall = !front_ready;
  assign quo_ready = !dst_valid || !dst_stall;

  // Restore the sign, then re-encode in the sample's own format
  always_comb begin
    sres = quo_tag.neg ? (~quo + 32'd1) : quo;
    unique case (quo_tag.fmt)
      pvs_pkg::FMT_U8:  enc = {24'd0, sres[7:0] + pvs_pkg::OFFSET8};
      pvs_pkg::FMT_S16: enc = {16'd0, sres[15:0]};
      pvs_pkg::FMT_S24: enc = {8'd0, sres[23:0]};
      pvs_pkg::FMT_S32: enc = sres;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (quo_ready) begin
      dst_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quo_ready && quo_valid) begin
      dst_data.sample_out    <= enc;
      dst_data.block_end_out <= quo_tag.block_end;
    end
  end

`ifndef ASSERT_OFF
  stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (dst_valid && dst_stall && quo_valid && mul_valid))
    else $error("input stalled while the pipeline has an empty stage");
`endif

endmodule

`default_nettype wire
